/* sv/ucdp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucdp_pkg
// Shared types and constants for the configuration descriptor parser.
// ----------------------------------------------------------------------------
package ucdp_pkg;

    localparam int unsigned PendDepth = 6;

    localparam logic [7:0] TypeInterface   = 8'd4;
    localparam logic [7:0] TypeEndpoint    = 8'd5;
    localparam logic [7:0] MinIfaceLen     = 8'd9;
    localparam logic [7:0] MinEpLen        = 8'd7;
    localparam logic [1:0] XferInterrupt   = 2'h3;
    localparam logic [7:0] DefaultInterval = 8'd10;

    typedef struct packed {
        logic [7:0]  intf_class;
        logic [7:0]  intf_subclass;
        logic [7:0]  intf_protocol;
        logic [7:0]  intf_number;
        logic [3:0]  ep_number;
        logic [15:0] ep_max_packet;
        logic [7:0]  ep_interval;
    } t_result;

endpackage : ucdp_pkg
`default_nettype wire

/* sv/ucdp_walker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucdp_walker
// Descriptor walk state and latched interface / endpoint fields. One byte is
// folded into the state per accepted transaction.
// ----------------------------------------------------------------------------
module ucdp_walker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    output ucdp_pkg::t_result      o_result
);
    import ucdp_pkg::*;

    logic [7:0] r_offset, n_offset;
    logic [7:0] r_length, n_length;
    logic [7:0] r_type,   n_type;
    logic       r_stopped, n_stopped;
    logic [7:0] r_pend [PendDepth];
    logic [7:0] n_pend [PendDepth];
    t_result    r_latch, n_latch;

    always_comb begin
        n_offset  = r_offset;
        n_length  = r_length;
        n_type    = r_type;
        n_stopped = r_stopped;
        n_pend    = r_pend;
        n_latch   = r_latch;
        if (!r_stopped) begin
            if (r_offset == 8'd0 && i_data_byte == 8'd0) begin
                // zero length: nothing more is parsed in this stream
                n_stopped = 1'b1;
            end else begin
                if (r_offset == 8'd0) begin
                    n_length = i_data_byte;
                    n_type   = 8'd0;
                    for (int k = 0; k < PendDepth; k++) begin
                        n_pend[k] = 8'd0;
                    end
                end else if (r_offset == 8'd1) begin
                    n_type = i_data_byte;
                end else begin
                    for (int k = 0; k < PendDepth; k++) begin
                        if (r_offset == 8'(k + 2)) begin
                            n_pend[k] = i_data_byte;
                        end
                    end
                end

                if ({1'b0, r_offset} + 9'd1 >= {1'b0, n_length}) begin
                    n_offset = 8'd0;
                    if (n_type == TypeInterface && n_length >= MinIfaceLen) begin
                        n_latch.intf_number   = n_pend[0];
                        n_latch.intf_class    = n_pend[3];
                        n_latch.intf_subclass = n_pend[4];
                        n_latch.intf_protocol = n_pend[5];
                    end
                    if (n_type == TypeEndpoint && n_length >= MinEpLen
                        && n_pend[1][1:0] == XferInterrupt && n_pend[0][7]) begin
                        n_latch.ep_number     = n_pend[0][3:0];
                        n_latch.ep_max_packet = {n_pend[3], n_pend[2]};
                        n_latch.ep_interval   = (n_pend[4] == 8'd0) ? DefaultInterval
                                                                    : n_pend[4];
                    end
                end else begin
                    n_offset = r_offset + 8'd1;
                end
            end
        end
    end

    assign o_result = n_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last_byte)) begin
            r_offset  <= '0;
            r_length  <= '0;
            r_type    <= '0;
            r_stopped <= 1'b0;
            for (int k = 0; k < PendDepth; k++) begin
                r_pend[k] <= '0;
            end
            r_latch   <= '0;
        end else if (i_en) begin
            r_offset  <= n_offset;
            r_length  <= n_length;
            r_type    <= n_type;
            r_stopped <= n_stopped;
            r_pend    <= n_pend;
            r_latch   <= n_latch;
        end
    end

endmodule : ucdp_walker
`default_nettype wire

/* sv/ucdp_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucdp_out_reg
// Result register with valid flag for the output channel.
// ----------------------------------------------------------------------------
module ucdp_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire ucdp_pkg::t_result i_result,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output ucdp_pkg::t_result      o_result
);
    import ucdp_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule : ucdp_out_reg
`default_nettype wire

/* sv/usb_config_descriptor_parser.sv */
// Output: a result appears in the cycle after the byte flagged last is accepted.
// Throughput: 1 byte per cycle unless stalled; the walk state updates in the accept cycle.
// Only a last byte stalls, while a previous result is still held unaccepted.
// Reset (i_rst_n low, synchronous): walk state, latches and valid clear.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_config_descriptor_parser
// Walks a configuration descriptor set byte by byte and reports the last
// complete interface descriptor and the last interrupt IN endpoint.
// ----------------------------------------------------------------------------
module usb_config_descriptor_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    // output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_intf_class,
    output logic [7:0]       o_intf_subclass,
    output logic [7:0]       o_intf_protocol,
    output logic [7:0]       o_intf_number,
    output logic [3:0]       o_intr_ep_number,
    output logic [15:0]      o_intr_ep_max_packet,
    output logic [7:0]       o_intr_ep_interval
);
    import ucdp_pkg::*;

    logic    in_accept;
    logic    result_load;
    t_result walk_result;
    t_result out_result;

    // A non-last byte only touches the walk state, so it is always taken.
    // A last byte produces a result and needs the result register free,
    // or being emptied in the same cycle.
    assign o_ready     = !i_last_byte || !o_valid || i_ready;
    assign in_accept   = i_valid && o_ready;
    assign result_load = in_accept && i_last_byte;

    // Walk state: offset within the current descriptor, length, type,
    // stopped flag, bytes 2..7 and the latched fields. The result is taken
    // from the latches after the current byte is folded in; the walker
    // clears itself on the last byte of the stream.
    ucdp_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_result    (walk_result)
    );

    // Result register separates the two channels.
    ucdp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (result_load),
        .i_result (walk_result),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_intf_class         = out_result.intf_class;
    assign o_intf_subclass      = out_result.intf_subclass;
    assign o_intf_protocol      = out_result.intf_protocol;
    assign o_intf_number        = out_result.intf_number;
    assign o_intr_ep_number     = out_result.ep_number;
    assign o_intr_ep_max_packet = out_result.ep_max_packet;
    assign o_intr_ep_interval   = out_result.ep_interval;

endmodule : usb_config_descriptor_parser
`default_nettype wire

/* tb/tb_usb_config_descriptor_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_config_descriptor_parser
// Streams configuration descriptor sets into the parser byte by byte. The
// stimulus is directed corner cases first, then random well-formed sets with
// some of them truncated, corrupted or cut short by a zero length byte, plus
// pure noise. A local descriptor walker predicts each report, and every
// report from the block is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_usb_config_descriptor_parser;
    import ucdp_pkg::*;

    // Descriptor types and attributes for stimulus; the walker also uses EpDirInBit.
    localparam logic [7:0] TypeConfig = 8'h02;
    localparam logic [7:0] TypeHid    = 8'h21;
    localparam logic [1:0] XferBulk   = 2'h2;
    localparam int         EpDirInBit = 7;

    localparam int RandomBytes      = 1280;
    localparam int MinRandomStreams = 24;
    localparam int CycleLimit       = 400000;
    localparam int DrainCycles      = 8;

    // Receiver stall patterns.
    typedef enum int {
        ReadyAlways,
        ReadyRandom,
        ReadyShortStall,
        ReadyLongStall
    } ready_mode_e;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_intf_class;
    logic [7:0]  o_intf_subclass;
    logic [7:0]  o_intf_protocol;
    logic [7:0]  o_intf_number;
    logic [3:0]  o_intr_ep_number;
    logic [15:0] o_intr_ep_max_packet;
    logic [7:0]  o_intr_ep_interval;

    usb_config_descriptor_parser dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_data_byte          (i_data_byte),
        .i_last_byte          (i_last_byte),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_intf_class         (o_intf_class),
        .o_intf_subclass      (o_intf_subclass),
        .o_intf_protocol      (o_intf_protocol),
        .o_intf_number        (o_intf_number),
        .o_intr_ep_number     (o_intr_ep_number),
        .o_intr_ep_max_packet (o_intr_ep_max_packet),
        .o_intr_ep_interval   (o_intr_ep_interval)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Descriptor walker: mirrors the block's view of the current set.
    // ------------------------------------------------------------------------
    logic [7:0] walk_offset;
    logic [7:0] walk_length;
    logic [7:0] walk_type;
    logic       walk_stopped;
    logic [7:0] walk_body[PendDepth];   // bytes at offsets 2..7
    t_result    latest_found;           // last complete iface / intr IN ep
    t_result    expected_reports[$];

    bit          failed = 1'b0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    bit          sender_idle = 1'b1;
    ready_mode_e stall_mode = ReadyRandom;
    logic [7:0]  stall_tick = 8'd0;
    int          cycle_count = 0;
    logic [7:0]  stream_q[$];

    function automatic void clear_walk();
        walk_offset  = 8'd0;
        walk_length  = 8'd0;
        walk_type    = 8'd0;
        walk_stopped = 1'b0;
        foreach (walk_body[k]) walk_body[k] = 8'd0;
        latest_found = '0;
    endfunction

    // Advance the walker by one accepted byte; a last byte yields a report.
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        if (!walk_stopped) begin
            if (walk_offset == 8'd0 && b == 8'd0) begin
                // zero length: nothing more is parsed in this set
                walk_stopped = 1'b1;
            end else begin
                if (walk_offset == 8'd0) begin
                    walk_length = b;
                    walk_type   = 8'd0;
                    foreach (walk_body[k]) walk_body[k] = 8'd0;
                end else if (walk_offset == 8'd1) begin
                    walk_type = b;
                end else if (int'(walk_offset) < 2 + PendDepth) begin
                    walk_body[3'(walk_offset - 8'd2)] = b;
                end
                if (int'(walk_offset) + 1 >= int'(walk_length)) begin
                    // descriptor complete on this byte
                    if (walk_type == TypeInterface && walk_length >= MinIfaceLen) begin
                        latest_found.intf_number   = walk_body[0];
                        latest_found.intf_class    = walk_body[3];
                        latest_found.intf_subclass = walk_body[4];
                        latest_found.intf_protocol = walk_body[5];
                    end
                    if (walk_type == TypeEndpoint && walk_length >= MinEpLen &&
                        walk_body[1][1:0] == XferInterrupt && walk_body[0][EpDirInBit]) begin
                        latest_found.ep_number     = walk_body[0][3:0];
                        latest_found.ep_max_packet = {walk_body[3], walk_body[2]};
                        latest_found.ep_interval   = (walk_body[4] == 8'd0) ?
                                                     DefaultInterval : walk_body[4];
                    end
                    walk_offset = 8'd0;
                end else begin
                    walk_offset = walk_offset + 8'd1;
                end
            end
        end
        if (last) begin
            expected_reports.push_back(latest_found);
            clear_walk();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Append one descriptor; head carries offsets 2..7 with offset 2 lowest.
    // Bytes past offset 7 are random filler.
    function automatic void put_desc(input logic [7:0] len, input logic [7:0] kind,
                                     input logic [47:0] head);
        stream_q.push_back(len);
        if (len > 8'd1) stream_q.push_back(kind);
        for (int k = 2; k < int'(len); k++) begin
            if (k < 8) stream_q.push_back(head[8*(k-2) +: 8]);
            else       stream_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // One input transaction. The sender runs in bursts; a gap lowers valid
    // only at the start of a burst, so valid never drops and rises in one step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_idle ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_byte(b, last);
        bytes_sent++;
    endtask

    // Send the built set, flagging its final byte as last.
    task automatic send_stream();
        for (int k = 0; k < stream_q.size(); k++) begin
            send_byte(stream_q[k], k == stream_q.size() - 1);
        end
        stream_q.delete();
    endtask

    // ------------------------------------------------------------------------
    // Receiver stalls and report checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        case (stall_mode)
            ReadyAlways:     i_ready <= 1'b1;
            ReadyRandom:     i_ready <= ($urandom_range(0, 3) != 0);
            ReadyShortStall: i_ready <= (stall_tick[1:0] != 2'b00);
            default:         i_ready <= (stall_tick[3:0] >= 4'd12);
        endcase
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : report_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $display("[%0t] report with nothing expected: class 0x%0h ep 0x%0h",
                         $time, o_intf_class, o_intr_ep_number);
                failed = 1'b1;
            end else begin
                want = expected_reports.pop_front();
                check_field("intf_class", 16'(want.intf_class), 16'(o_intf_class));
                check_field("intf_subclass", 16'(want.intf_subclass),
                            16'(o_intf_subclass));
                check_field("intf_protocol", 16'(want.intf_protocol),
                            16'(o_intf_protocol));
                check_field("intf_number", 16'(want.intf_number), 16'(o_intf_number));
                check_field("intr_ep_number", 16'(want.ep_number),
                            16'(o_intr_ep_number));
                check_field("intr_ep_max_packet", want.ep_max_packet,
                            o_intr_ep_max_packet);
                check_field("intr_ep_interval", 16'(want.ep_interval),
                            16'(o_intr_ep_interval));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("tb_usb_config_descriptor_parser: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Sets of a single byte: empty reports, with the last flag on a length
    // byte of all ones, of zero, and of one.
    task automatic test_lone_bytes();
        stream_q.push_back(8'hFF);
        send_stream();
        stream_q.push_back(8'h00);
        send_stream();
        stream_q.push_back(8'h01);
        send_stream();
    endtask

    // Interface and interrupt IN endpoint with extreme field values; the
    // endpoint ends on the last byte and still counts. Interval 0 maps to 10.
    task automatic test_full_descriptors();
        put_desc(MinIfaceLen, TypeInterface,
                 {8'hA5, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF});
        put_desc(MinEpLen, TypeEndpoint,
                 {8'h00, 8'h00, 8'hFF, 8'hFF, {6'h00, XferInterrupt}, 8'h8F});
        send_stream();
    endtask

    // Everything here must leave the report empty: a length-one descriptor,
    // short interface and endpoint, an OUT interrupt and a bulk IN endpoint,
    // then a zero length byte that hides a valid endpoint behind it.
    task automatic test_skipped_descriptors();
        stream_q.push_back(8'h01);
        put_desc(8'd3, TypeInterface, 48'h0102_0304_0506);
        put_desc(8'd6, TypeEndpoint,
                 {8'h00, 8'h04, 8'h00, 8'h40, {6'h00, XferInterrupt}, 8'h81});
        put_desc(MinEpLen, TypeEndpoint,
                 {8'h00, 8'h04, 8'h00, 8'h40, {6'h00, XferInterrupt}, 8'h01});
        put_desc(MinEpLen, TypeEndpoint,
                 {8'h00, 8'h04, 8'h02, 8'h00, {6'h00, XferBulk}, 8'h82});
        stream_q.push_back(8'h00);
        put_desc(MinEpLen, TypeEndpoint,
                 {8'h00, 8'h08, 8'h00, 8'h08, {6'h00, XferInterrupt}, 8'h83});
        send_stream();
    endtask

    // Interface cut off before its final byte has no effect.
    task automatic test_truncated();
        put_desc(MinIfaceLen, TypeInterface, 48'h0301_0100_0102);
        while (stream_q.size() > 5) void'(stream_q.pop_back());
        send_stream();
    endtask

    // Back-to-back one-byte sets against a long receiver stall, so a last
    // byte arrives while the previous report is still held.
    task automatic test_back_to_back_reports();
        sender_idle = 1'b0;
        stall_mode  = ReadyLongStall;
        stream_q.push_back(8'h55);
        send_stream();
        stream_q.push_back(8'hAA);
        send_stream();
        stream_q.push_back(8'h0F);
        send_stream();
        stream_q.push_back(8'hF0);
        send_stream();
        sender_idle = 1'b1;
        stall_mode  = ReadyRandom;
    endtask

    // Mostly plausible configuration sets with random content; some are
    // truncated, corrupted or stopped early, and a tenth are raw noise.
    task automatic test_random_streams();
        int          start_bytes;
        int          streams;
        int          n_iface;
        int          n_ep;
        int          cut;
        logic [7:0]  len;
        logic [47:0] head;
        start_bytes = bytes_sent;
        streams = 0;
        while (bytes_sent - start_bytes < RandomBytes || streams < MinRandomStreams) begin
            // some sets run with no idling on either side
            sender_idle = ($urandom_range(0, 4) != 0);
            stall_mode  = sender_idle ? ready_mode_e'($urandom_range(0, 3)) : ReadyAlways;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 24)) stream_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                put_desc(8'd9, TypeConfig, 48'({$urandom(), $urandom()}));
                n_iface = $urandom_range(1, 2);
                repeat (n_iface) begin
                    if ($urandom_range(0, 24) == 0) stream_q.push_back(8'h00);
                    case ($urandom_range(0, 9))
                        0:       len = 8'($urandom_range(2, 8));
                        1, 2:    len = 8'($urandom_range(10, 14));
                        default: len = MinIfaceLen;
                    endcase
                    put_desc(len, TypeInterface, 48'({$urandom(), $urandom()}));
                    if ($urandom_range(0, 2) == 0)
                        put_desc(8'd9, TypeHid, 48'({$urandom(), $urandom()}));
                    n_ep = $urandom_range(0, 3);
                    repeat (n_ep) begin
                        case ($urandom_range(0, 9))
                            0:       len = 8'($urandom_range(2, 6));
                            1:       len = 8'($urandom_range(8, 9));
                            default: len = MinEpLen;
                        endcase
                        // bias toward interrupt IN, interval 0 now and then
                        head = 48'({$urandom(), $urandom()});
                        if ($urandom_range(0, 3) != 0) head[EpDirInBit] = 1'b1;
                        if ($urandom_range(0, 3) != 0) head[9:8] = XferInterrupt;
                        if ($urandom_range(0, 3) == 0) head[39:32] = 8'h00;
                        put_desc(len, TypeEndpoint, head);
                    end
                end
                case ($urandom_range(0, 7))
                    0: begin
                        cut = $urandom_range(1, stream_q.size());
                        while (stream_q.size() > cut) void'(stream_q.pop_back());
                    end
                    1: begin
                        cut = $urandom_range(0, stream_q.size() - 1);
                        stream_q[cut] = 8'($urandom_range(0, 255));
                    end
                    default: ;
                endcase
            end
            send_stream();
            streams++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_walk();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_lone_bytes();
        test_full_descriptors();
        test_skipped_descriptors();
        test_truncated();
        test_back_to_back_reports();
        test_random_streams();

        // drain: stall patterns may still hold the final report
        i_valid <= 1'b0;
        stall_mode = ReadyRandom;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (!failed) begin
            $display("tb_usb_config_descriptor_parser: PASS");
        end else begin
            $display("tb_usb_config_descriptor_parser: FAIL");
        end
        $finish;
    end

endmodule
